>>> hw/rtl/cau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and saturation helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROD_W        = 64;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  // Operation codes as they arrive on the kind field
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CONJ = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MAG  = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_CONJ,
    OP_MAG,
    OP_NONE
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_SAT      = 2'd2
  } status_e;

  // Classified item as it waits in the queue
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } entry_t;

  // Saturated 32-bit word and its overflow flag
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } word_t;

  // Sign and magnitude to a saturated two's complement word
  function automatic word_t sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
    word_t w;
    if (!neg) begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        w.val = 32'h7FFF_FFFF;
        w.sat = 1'b1;
      end else begin
        w.val = mag[DATA_W-1:0];
        w.sat = 1'b0;
      end
    end else begin
      if (mag > 64'h0000_0000_8000_0000) begin
        w.val = 32'h8000_0000;
        w.sat = 1'b1;
      end else begin
        w.val = 32'h0 - mag[DATA_W-1:0];
        w.sat = 1'b0;
      end
    end
    return w;
  endfunction

  // Clamp a 33-bit signed value into 32 bits
  function automatic word_t sat_s33(input logic signed [DATA_W:0] v);
    logic [DATA_W:0] mag;
    mag = v[DATA_W] ? (33'h0 - v) : v;
    return sat_mag(v[DATA_W], PROD_W'(mag));
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Classifies an incoming item into an internal operation and its operands.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic [cau_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_re_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_im_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_re_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_im_i,
  output cau_pkg::entry_t                   entry_o
);
  import cau_pkg::*;

  // Decode the operation; magnitude squares a, so route a onto the b operands
  always_comb begin
    entry_o.a_re = a_re_i;
    entry_o.a_im = a_im_i;
    entry_o.b_re = b_re_i;
    entry_o.b_im = b_im_i;
    case (kind_i)
      KIND_ADD:  entry_o.op = OP_ADD;
      KIND_MUL:  entry_o.op = OP_MUL;
      KIND_DIV:  entry_o.op = OP_DIV;
      KIND_CONJ: entry_o.op = OP_CONJ;
      KIND_MAG: begin
        entry_o.op   = OP_MAG;
        entry_o.b_re = a_re_i;
        entry_o.b_im = a_im_i;
      end
      default:   entry_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/cau_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_queue
// Short item queue between the front and the back of the unit.
// ----------------------------------------------------------------------------
module cau_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cau_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            nonempty_o,
  output cau_pkg::entry_t entry_o
);
  import cau_pkg::*;

  entry_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty_o = (count_q != '0);
  assign entry_o    = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cau_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, a one-bit-per-stage quotient pipeline
// for both parts of a quotient, a two-bit-per-stage square root, rounding and
// saturation into the output register.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_take_o,
  input  cau_pkg::entry_t                   entry_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cau_pkg::DATA_W-1:0] res_re_o,
  output logic signed [cau_pkg::DATA_W-1:0] res_im_o,
  output logic [cau_pkg::STATUS_W-1:0]      status_o
);
  import cau_pkg::*;

  localparam int unsigned QBITS    = 33;
  localparam int unsigned DS       = QBITS;
  localparam int unsigned SQ_STEPS = DATA_W;
  localparam int unsigned SQR_W    = DATA_W + 1;
  localparam int unsigned NUM_W    = PROD_W + FRAC_BITS;
  localparam int unsigned CMP_W    = PROD_W + QBITS;

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              sat;
  } early_t;

  typedef struct packed {
    op_e               op;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic              zero;
    logic [PROD_W-1:0] den;
    early_t            early;
  } carry_t;

  logic adv;
  logic out_vld_q;

  // Whole pipeline moves unless the output register is held
  assign adv       = !out_vld_q || !out_stall_i;
  assign in_take_o = adv && in_valid_i;

  // -------------------- stage 1: operands
  logic   s1_vld_q;
  entry_t s1_q;

  // -------------------- stage 2: products and simple results
  logic                     s2_vld_q;
  op_e                      s2_op_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, q_r_q, q_i_q;
  early_t                   s2_early_q, s2_early_d;

  always_comb begin
    word_t wr, wi;
    wr = '0;
    wi = '0;
    case (s1_q.op)
      OP_ADD: begin
        wr = sat_s33((DATA_W+1)'(s1_q.a_re) + (DATA_W+1)'(s1_q.b_re));
        wi = sat_s33((DATA_W+1)'(s1_q.a_im) + (DATA_W+1)'(s1_q.b_im));
      end
      OP_CONJ: begin
        wr = sat_s33((DATA_W+1)'(s1_q.a_re));
        wi = sat_s33(-(DATA_W+1)'(s1_q.a_im));
      end
      default: ;
    endcase
    s2_early_d.re  = wr.val;
    s2_early_d.im  = wi.val;
    s2_early_d.sat = wr.sat | wi.sat;
  end

  // -------------------- stage 3: sums of products
  logic                     s3_vld_q;
  op_e                      s3_op_q;
  logic signed [PROD_W:0]   n_re_q, n_im_q, n_re_d, n_im_d;
  logic [PROD_W-1:0]        s3_den_q;
  early_t                   s3_early_q;

  always_comb begin
    n_re_d = '0;
    n_im_d = '0;
    case (s2_op_q)
      OP_MUL: begin
        n_re_d = (PROD_W+1)'(p_rr_q) - (PROD_W+1)'(p_ii_q);
        n_im_d = (PROD_W+1)'(p_ri_q) + (PROD_W+1)'(p_ir_q);
      end
      OP_DIV: begin
        n_re_d = (PROD_W+1)'(p_rr_q) + (PROD_W+1)'(p_ii_q);
        n_im_d = (PROD_W+1)'(p_ir_q) - (PROD_W+1)'(p_ri_q);
      end
      OP_MAG: begin
        n_re_d = (PROD_W+1)'(p_rr_q) + (PROD_W+1)'(p_ii_q);
      end
      default: ;
    endcase
  end

  // -------------------- stage 4: sign and magnitude
  logic              s4_vld_q;
  op_e               s4_op_q;
  logic              s4_neg_re_q, s4_neg_im_q, s4_zero_q;
  logic [PROD_W-1:0] s4_mag_re_q, s4_mag_im_q, s4_den_q;
  early_t            s4_early_q;

  // -------------------- stage 5: rounding of products, divider set-up
  logic              chain_vld_q [DS+1];
  carry_t            chain_c_q   [DS+1];
  logic [PROD_W-1:0] dre_rem_q   [DS+1];
  logic [QBITS-1:0]  dre_tail_q  [DS+1];
  logic [QBITS-1:0]  dre_quo_q   [DS+1];
  logic [PROD_W-1:0] dim_rem_q   [DS+1];
  logic [QBITS-1:0]  dim_tail_q  [DS+1];
  logic [QBITS-1:0]  dim_quo_q   [DS+1];
  logic [PROD_W-1:0] sq_v_q      [DS+1];
  logic [SQR_W-1:0]  sq_rem_q    [DS+1];
  logic [DATA_W-1:0] sq_root_q   [DS+1];

  carry_t            c0_d;
  logic [NUM_W-1:0]  num_re, num_im;

  always_comb begin
    logic [PROD_W-1:0] rs_re, rs_im;
    word_t             wr, wi;
    rs_re = (s4_mag_re_q >> FRAC_BITS) + PROD_W'(s4_mag_re_q[FRAC_BITS-1]);
    rs_im = (s4_mag_im_q >> FRAC_BITS) + PROD_W'(s4_mag_im_q[FRAC_BITS-1]);
    wr    = sat_mag(s4_neg_re_q, rs_re);
    wi    = sat_mag(s4_neg_im_q, rs_im);
    c0_d.op     = s4_op_q;
    c0_d.neg_re = s4_neg_re_q;
    c0_d.neg_im = s4_neg_im_q;
    c0_d.zero   = s4_zero_q;
    c0_d.den    = s4_den_q;
    c0_d.ovf_re = (CMP_W'(s4_mag_re_q) << FRAC_BITS) >= (CMP_W'(s4_den_q) << QBITS);
    c0_d.ovf_im = (CMP_W'(s4_mag_im_q) << FRAC_BITS) >= (CMP_W'(s4_den_q) << QBITS);
    if (s4_op_q == OP_MUL) begin
      c0_d.early.re  = wr.val;
      c0_d.early.im  = wi.val;
      c0_d.early.sat = wr.sat | wi.sat;
    end else begin
      c0_d.early = s4_early_q;
    end
  end

  assign num_re = {s4_mag_re_q, FRAC_BITS'(0)};
  assign num_im = {s4_mag_im_q, FRAC_BITS'(0)};

  // -------------------- rounding stage and output register
  logic              r1_vld_q;
  carry_t            r1_c_q;
  logic [QBITS:0]    r1_qre_q, r1_qim_q;
  logic [QBITS-1:0]  r1_root_q;

  // Hold valid bits; advance them together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q       <= 1'b0;
      s2_vld_q       <= 1'b0;
      s3_vld_q       <= 1'b0;
      s4_vld_q       <= 1'b0;
      chain_vld_q[0] <= 1'b0;
      r1_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
    end else if (adv) begin
      s1_vld_q       <= in_valid_i;
      s2_vld_q       <= s1_vld_q;
      s3_vld_q       <= s2_vld_q;
      s4_vld_q       <= s3_vld_q;
      chain_vld_q[0] <= s4_vld_q;
      r1_vld_q       <= chain_vld_q[DS];
      out_vld_q      <= r1_vld_q;
    end
  end

  // Front stages of the datapath
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q        <= entry_i;
      s2_op_q     <= s1_q.op;
      p_rr_q      <= s1_q.a_re * s1_q.b_re;
      p_ii_q      <= s1_q.a_im * s1_q.b_im;
      p_ri_q      <= s1_q.a_re * s1_q.b_im;
      p_ir_q      <= s1_q.a_im * s1_q.b_re;
      q_r_q       <= s1_q.b_re * s1_q.b_re;
      q_i_q       <= s1_q.b_im * s1_q.b_im;
      s2_early_q  <= s2_early_d;
      s3_op_q     <= s2_op_q;
      n_re_q      <= n_re_d;
      n_im_q      <= n_im_d;
      s3_den_q    <= PROD_W'(q_r_q) + PROD_W'(q_i_q);
      s3_early_q  <= s2_early_q;
      s4_op_q     <= s3_op_q;
      s4_neg_re_q <= n_re_q[PROD_W];
      s4_neg_im_q <= n_im_q[PROD_W];
      s4_mag_re_q <= n_re_q[PROD_W] ? PROD_W'(-n_re_q) : n_re_q[PROD_W-1:0];
      s4_mag_im_q <= n_im_q[PROD_W] ? PROD_W'(-n_im_q) : n_im_q[PROD_W-1:0];
      s4_den_q    <= s3_den_q;
      s4_zero_q   <= (s3_den_q == '0);
      s4_early_q  <= s3_early_q;
    end
  end

  // Load the quotient and root pipelines
  always_ff @(posedge clk_i) begin
    if (adv) begin
      chain_c_q[0]  <= c0_d;
      dre_rem_q[0]  <= PROD_W'(num_re >> QBITS);
      dre_tail_q[0] <= num_re[QBITS-1:0];
      dre_quo_q[0]  <= '0;
      dim_rem_q[0]  <= PROD_W'(num_im >> QBITS);
      dim_tail_q[0] <= num_im[QBITS-1:0];
      dim_quo_q[0]  <= '0;
      sq_v_q[0]     <= s4_mag_re_q;
      sq_rem_q[0]   <= '0;
      sq_root_q[0]  <= '0;
    end
  end

  // One quotient bit per stage for each part, two radicand bits for the root
  for (genvar k = 0; k < DS; k++) begin : g_step
    logic [PROD_W:0]   re_trial, im_trial, den_ext;
    logic              re_ge, im_ge;

    assign den_ext  = {1'b0, chain_c_q[k].den};
    assign re_trial = {dre_rem_q[k], dre_tail_q[k][QBITS-1]};
    assign im_trial = {dim_rem_q[k], dim_tail_q[k][QBITS-1]};
    assign re_ge    = re_trial >= den_ext;
    assign im_ge    = im_trial >= den_ext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        chain_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        chain_vld_q[k+1] <= chain_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        chain_c_q[k+1]  <= chain_c_q[k];
        dre_rem_q[k+1]  <= re_ge ? PROD_W'(re_trial - den_ext) : re_trial[PROD_W-1:0];
        dre_tail_q[k+1] <= {dre_tail_q[k][QBITS-2:0], 1'b0};
        dre_quo_q[k+1]  <= {dre_quo_q[k][QBITS-2:0], re_ge};
        dim_rem_q[k+1]  <= im_ge ? PROD_W'(im_trial - den_ext) : im_trial[PROD_W-1:0];
        dim_tail_q[k+1] <= {dim_tail_q[k][QBITS-2:0], 1'b0};
        dim_quo_q[k+1]  <= {dim_quo_q[k][QBITS-2:0], im_ge};
      end
    end

    if (k < SQ_STEPS) begin : g_sqrt
      logic [SQR_W+1:0] sq_trial, sq_test;
      logic             sq_ge;

      assign sq_trial = {sq_rem_q[k], sq_v_q[k][PROD_W-1:PROD_W-2]};
      assign sq_test  = (SQR_W+2)'({sq_root_q[k], 2'b01});
      assign sq_ge    = sq_trial >= sq_test;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          sq_v_q[k+1]    <= {sq_v_q[k][PROD_W-3:0], 2'b00};
          sq_rem_q[k+1]  <= sq_ge ? SQR_W'(sq_trial - sq_test) : sq_trial[SQR_W-1:0];
          sq_root_q[k+1] <= {sq_root_q[k][DATA_W-2:0], sq_ge};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sq_v_q[k+1]    <= sq_v_q[k];
          sq_rem_q[k+1]  <= sq_rem_q[k];
          sq_root_q[k+1] <= sq_root_q[k];
        end
      end
    end
  end

  // Round quotients and root to nearest
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_c_q    <= chain_c_q[DS];
      r1_qre_q  <= {1'b0, dre_quo_q[DS]} +
                   (QBITS+1)'({dre_rem_q[DS], 1'b0} >= {1'b0, chain_c_q[DS].den});
      r1_qim_q  <= {1'b0, dim_quo_q[DS]} +
                   (QBITS+1)'({dim_rem_q[DS], 1'b0} >= {1'b0, chain_c_q[DS].den});
      r1_root_q <= {1'b0, sq_root_q[DS]} +
                   QBITS'(sq_rem_q[DS] > SQR_W'(sq_root_q[DS]));
    end
  end

  // Select and saturate the result
  logic [DATA_W-1:0]   res_re_d, res_im_d;
  logic [STATUS_W-1:0] status_d;

  always_comb begin
    word_t wr, wi;
    wr = '0;
    wi = '0;
    case (r1_c_q.op)
      OP_DIV: begin
        wr = sat_mag(r1_c_q.neg_re, PROD_W'(r1_qre_q));
        wi = sat_mag(r1_c_q.neg_im, PROD_W'(r1_qim_q));
        if (r1_c_q.ovf_re) begin
          wr.val = r1_c_q.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
          wr.sat = 1'b1;
        end
        if (r1_c_q.ovf_im) begin
          wi.val = r1_c_q.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
          wi.sat = 1'b1;
        end
      end
      OP_MAG: begin
        wr = sat_mag(1'b0, PROD_W'(r1_root_q));
      end
      default: begin
        wr.val = r1_c_q.early.re;
        wr.sat = r1_c_q.early.sat;
        wi.val = r1_c_q.early.im;
        wi.sat = 1'b0;
      end
    endcase
    if (r1_c_q.op == OP_DIV && r1_c_q.zero) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = STATUS_DIV_ZERO;
    end else begin
      res_re_d = wr.val;
      res_im_d = wi.val;
      status_d = (wr.sat | wi.sat) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_o <= res_re_d;
      res_im_o <= res_im_d;
      status_o <= status_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
`default_nettype wire

>>> hw/rtl/complex_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, multiply, divide, conjugate and magnitude in signed fixed point.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while its input queue is not full and
// returns one result per item, in order. An item passes the input queue,
// the operand, product, sum and sign stages, the divider set-up stage, the
// 33-stage quotient pipeline (one quotient bit per stage, which also carries
// the square root), one rounding stage and the output register. A stall on
// the output holds the whole pipeline; the four-entry input queue keeps
// taking items meanwhile, and in_stall_o rises only when it is full.
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cau_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_re_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_im_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_re_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_im_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cau_pkg::DATA_W-1:0] res_re_o,
  output logic signed [cau_pkg::DATA_W-1:0] res_im_o,
  output logic [cau_pkg::STATUS_W-1:0]      status_o
);
  import cau_pkg::*;

  entry_t front_entry, head_entry;
  logic   q_full, q_nonempty, q_pop;

  // Classify the incoming item
  cau_front u_front (
    .kind_i  (kind_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .entry_o (front_entry)
  );

  // Queue items between front and back
  cau_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && !q_full),
    .entry_i    (front_entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .entry_o    (head_entry)
  );

  assign in_stall_o = q_full;

  // Execute
  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_nonempty),
    .in_take_o   (q_pop),
    .entry_i     (head_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_re_o    (res_re_o),
    .res_im_o    (res_im_o),
    .status_o    (status_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/cau_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [cau_pkg::DATA_W-1:0] res_re_o,
  input logic signed [cau_pkg::DATA_W-1:0] res_im_o,
  input logic [cau_pkg::STATUS_W-1:0]      status_o
);
  import cau_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(res_re_o) && $stable(res_im_o) && $stable(status_o))
    else $error("stalled result changed");

  // A zero divisor gives a zero result
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_DIV_ZERO |-> res_re_o == '0 && res_im_o == '0)
    else $error("divide by zero with nonzero result");

  // Status carries a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STATUS_OK || status_o == STATUS_DIV_ZERO ||
                    status_o == STATUS_SAT)
    else $error("undefined status code");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .res_re_o    (res_re_o),
  .res_im_o    (res_im_o),
  .status_o    (status_o)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex arithmetic unit: directed corner items
// and random operand streams, checked result by result against a predictor.
// ----------------------------------------------------------------------------
module tb;
  import cau_pkg::*;

  localparam int unsigned FB        = FRAC_BITS_DEF;
  localparam int unsigned N_RANDOM  = 1750;
  localparam int unsigned LATENCY   = 60;
  localparam int unsigned MAX_CYCLE = 400000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [31:0]       a_re;
    logic [31:0]       a_im;
    logic [31:0]       b_re;
    logic [31:0]       b_im;
  } op_item_t;

  typedef struct packed {
    logic [31:0]         re;
    logic [31:0]         im;
    logic [STATUS_W-1:0] status;
  } cplx_res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [KIND_W-1:0] kind_i;
  logic signed [31:0] a_re_i, a_im_i, b_re_i, b_im_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] res_re_o, res_im_o;
  logic [STATUS_W-1:0] status_o;

  op_item_t  pending_ops[$];
  cplx_res_t expected_res[$];
  int unsigned err_count = 0;
  int unsigned cycle_count;
  bit          stim_done = 1'b0;
  bit          pause_send = 1'b0;
  bit          hold_off = 1'b0;
  int unsigned send_gap;
  int unsigned recv_gap;

  complex_arithmetic_unit #(.FRAC_BITS(FB)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .out_valid_o, .out_stall_i, .res_re_o, .res_im_o, .status_o
  );

  // Run the clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Saturate a sign and magnitude into a 32-bit word
  function automatic logic [31:0] clamp_word(input bit neg, input logic [127:0] mag,
                                             inout bit sat);
    if (!neg) begin
      if (mag > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 128'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'h0 - mag[31:0];
  endfunction

  function automatic logic [31:0] clamp_signed(input logic signed [127:0] v, inout bit sat);
    logic [127:0] m;
    m = v < 0 ? -v : v;
    return clamp_word(v < 0, m, sat);
  endfunction

  // Round half away from zero of |v| / 2^FB, then clamp
  function automatic logic [31:0] round_fix(input logic signed [127:0] v, inout bit sat);
    logic [127:0] m;
    m = v < 0 ? -v : v;
    m = (m >> FB) + ((m >> (FB - 1)) & 1);
    return clamp_word(v < 0, m, sat);
  endfunction

  // Round of |num| * 2^FB / den, half up on magnitude
  function automatic logic [31:0] div_fix(input logic signed [127:0] num,
                                          input logic [127:0] den, inout bit sat);
    logic [127:0] m, q, r;
    m = num < 0 ? -num : num;
    q = (m << FB) / den;
    r = (m << FB) % den;
    if (r >= den - r) q = q + 1;
    return clamp_word(num < 0, q, sat);
  endfunction

  function automatic logic [127:0] root_round(input logic [127:0] v);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'h1_0000_0000;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    if (v - lo * lo > lo) lo = lo + 1;
    return lo;
  endfunction

  // Predict the result of one operation
  function automatic cplx_res_t complex_result(input op_item_t it);
    cplx_res_t r;
    bit sat;
    logic signed [127:0] ar, ai, br, bi;
    logic [127:0] den;
    sat = 1'b0;
    r = '0;
    ar = $signed(it.a_re);
    ai = $signed(it.a_im);
    br = $signed(it.b_re);
    bi = $signed(it.b_im);
    case (it.kind)
      KIND_ADD: begin
        r.re = clamp_signed(ar + br, sat);
        r.im = clamp_signed(ai + bi, sat);
      end
      KIND_MUL: begin
        r.re = round_fix(ar * br - ai * bi, sat);
        r.im = round_fix(ar * bi + br * ai, sat);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.status = STATUS_DIV_ZERO;
        else begin
          r.re = div_fix(ar * br + ai * bi, den, sat);
          r.im = div_fix(ai * br - ar * bi, den, sat);
        end
      end
      KIND_CONJ: begin
        r.re = clamp_signed(ar, sat);
        r.im = clamp_signed(-ai, sat);
      end
      KIND_MAG: r.re = clamp_word(1'b0, root_round(ar * ar + ai * ai), sat);
      default: ;
    endcase
    if (r.status == STATUS_OK && sat) r.status = STATUS_SAT;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'(signed'($urandom_range(0, 8)) - 4) << FB;
      2: return 32'($urandom_range(0, 255)) - 128;
      3: return $urandom() >>> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(input logic [KIND_W-1:0] k, input logic [31:0] ar,
                          input logic [31:0] ai, input logic [31:0] br,
                          input logic [31:0] bi);
    op_item_t it;
    it.kind = k;
    it.a_re = ar;
    it.a_im = ai;
    it.b_re = br;
    it.b_im = bi;
    pending_ops.push_back(it);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // Fill the stimulus queue
  initial begin
    op_item_t it;
    queue_op(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_op(KIND_ADD, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0);
    queue_op(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(KIND_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
    queue_op(KIND_MUL, 32'hFFFF_8000, 32'h0, 32'h0000_0001, 32'h0);
    queue_op(KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    queue_op(KIND_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    queue_op(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
    queue_op(KIND_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_op(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_op(KIND_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0);
    queue_op(KIND_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(KIND_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    queue_op(KIND_MAG, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0);
    queue_op(KIND_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(3'd5, 32'h1, 32'h2, 32'h3, 32'h4);
    queue_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(3'd7, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < N_RANDOM; i++) begin
      it.kind = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      it.a_re = rand_operand();
      it.a_im = rand_operand();
      it.b_re = rand_operand();
      it.b_im = rand_operand();
      if (it.kind == KIND_DIV && $urandom_range(0, 15) == 0) begin
        it.b_re = 0;
        it.b_im = 0;
      end
      pending_ops.push_back(it);
    end
  end

  // Drive items from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= '0;
      a_re_i <= '0;
      a_im_i <= '0;
      b_re_i <= '0;
      b_im_i <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_res.push_back(complex_result({kind_i, a_re_i, a_im_i, b_re_i, b_im_i}));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0 || pause_send || pending_ops.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap != 0) send_gap <= send_gap - 1;
          if (pending_ops.size() == 0 && !(in_valid_i && !in_stall_o)) stim_done <= 1'b1;
        end else begin
          op_item_t it;
          it = pending_ops.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= it.kind;
          a_re_i <= it.a_re;
          a_im_i <= it.a_im;
          b_re_i <= it.b_re;
          b_im_i <= it.b_im;
          // Alternate bursts with no gaps and stretches of random gaps
          send_gap <= (pending_ops.size() % 400 < 150) ? 0 : $urandom_range(0, 11);
        end
      end
    end
  end

  // Monitor and check results; drive the output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", res_re_o, 32'h0);
        end else begin
          cplx_res_t e;
          e = expected_res.pop_front();
          if (res_re_o !== e.re) report_mismatch("res_re", res_re_o, e.re);
          if (res_im_o !== e.im) report_mismatch("res_im", res_im_o, e.im);
          if (status_o !== e.status) report_mismatch("status", 32'(status_o), 32'(e.status));
        end
      end
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap != 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (out_valid_o && !out_stall_i) begin
        // Draw the wait for the next result; quiet stretches have none
        recv_gap <= (cycle_count % 3000 < 1000) ? 0 : $urandom_range(0, 11);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Reset, pressure phases, end of run
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Long receiver hold-off while the sender keeps offering items
    wait (pending_ops.size() < N_RANDOM - 100);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
    // Sender pause until every expected result has drained
    wait (pending_ops.size() < N_RANDOM / 2);
    @(posedge clk_i);
    pause_send <= 1'b1;
    wait (expected_res.size() == 0 && !in_valid_i);
    @(posedge clk_i);
    pause_send <= 1'b0;
    wait (stim_done && expected_res.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
    if (err_count == 0 && expected_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLE) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
